// ----- sv/tsla_pkg.sv -----
// package for the tagged slot lease allocator
// request and result types, mode, status and register index codes
// no dependencies
package tsla_pkg;

  // default sizes handed to the top level
  localparam int unsigned DEF_MAX_SLOTS  = 16;
  localparam int unsigned DEF_OWNER_BITS = 12;

  // field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ID_W     = 12;
  localparam int unsigned EPOCH_W  = 64;
  localparam int unsigned SLOTNUM_W = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned GRANT_W  = 4;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned CFG_IDX_W = 1;

  // request modes
  localparam logic [MODE_W-1:0] MODE_ACQUIRE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUP     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOMATCH = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 3'd4;

  // configuration register indexes and reset value
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLOTS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_SLOTS = 1'b1;
  localparam logic [CFG_W-1:0]     CFG_SLOTS_RESET    = 5'd16;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic                 pool_select;
    logic [ID_W-1:0]      owner_id;
    logic [EPOCH_W-1:0]   owner_epoch;
    logic [SLOTNUM_W-1:0] slot_number;
  } tsla_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [GRANT_W-1:0]  granted_slot;
    logic [COUNT_W-1:0]  used_count;
    logic [COUNT_W-1:0]  free_count;
  } tsla_rsp_t;

  // write control from the sequencer to the slot store
  typedef struct packed {
    logic en;
    logic set_valid;
    logic pool;
  } tsla_wr_ctl_t;

endpackage

// ----- sv/tagged_slot_lease_allocator.sv -----
// Tagged slot lease allocator with an active and a transfer pool. A request
// is taken when start is high and busy is low; it acquires the lowest free
// slot for an owner tag, releases a given slot whose tag matches, or looks a
// tag up. The result is shown on rsp_o for exactly one cycle while
// result_valid_o is high and cannot be held off. After acceptance the
// pool is scanned one slot per cycle through the single read port of the tag
// memory, followed by a drain state and a commit state; the result strobe
// appears in the cycle after the commit, when busy is already low.
// depends on tsla_pkg, tsla_slot_store, tsla_sequencer
module tagged_slot_lease_allocator import tsla_pkg::*; #(
  parameter int unsigned MAX_SLOTS  = DEF_MAX_SLOTS,
  parameter int unsigned OWNER_BITS = DEF_OWNER_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  tsla_req_t            req_i,
  output logic                 result_valid_o,
  output tsla_rsp_t            rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [CFG_W-1:0]      active_slots_q, transfer_slots_q;
  logic                  rd_pool;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_valid;
  logic [OWNER_BITS-1:0] rd_owner;
  logic [EPOCH_W-1:0]    rd_epoch;
  tsla_wr_ctl_t          wr_ctl;
  logic [IDX_W-1:0]      wr_idx;
  logic [OWNER_BITS-1:0] wr_owner;
  logic [EPOCH_W-1:0]    wr_epoch;

  // capacity registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_slots_q   <= CFG_SLOTS_RESET;
      transfer_slots_q <= CFG_SLOTS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACTIVE_SLOTS:   active_slots_q   <= cfg_wdata_i;
        CFG_TRANSFER_SLOTS: transfer_slots_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tsla_sequencer #(
    .MAX_SLOTS  (MAX_SLOTS),
    .OWNER_BITS (OWNER_BITS)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_i            (req_i),
    .active_slots_i   (active_slots_q),
    .transfer_slots_i (transfer_slots_q),
    .rd_pool_o        (rd_pool),
    .rd_idx_o         (rd_idx),
    .rd_valid_i       (rd_valid),
    .rd_owner_i       (rd_owner),
    .rd_epoch_i       (rd_epoch),
    .wr_ctl_o         (wr_ctl),
    .wr_idx_o         (wr_idx),
    .wr_owner_o       (wr_owner),
    .wr_epoch_o       (wr_epoch),
    .rsp_o            (rsp_o),
    .rsp_valid_o      (result_valid_o)
  );

  tsla_slot_store #(
    .MAX_SLOTS  (MAX_SLOTS),
    .OWNER_BITS (OWNER_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_pool_i  (rd_pool),
    .rd_idx_i   (rd_idx),
    .rd_valid_o (rd_valid),
    .rd_owner_o (rd_owner),
    .rd_epoch_o (rd_epoch),
    .wr_ctl_i   (wr_ctl),
    .wr_idx_i   (wr_idx),
    .wr_owner_i (wr_owner),
    .wr_epoch_i (wr_epoch)
  );

endmodule

// ----- sv/tsla_slot_store.sv -----
// slot store: owner tag memory for both pools plus per-slot valid flops
// one registered read port and one write port
// depends on tsla_pkg
module tsla_slot_store import tsla_pkg::*; #(
  parameter int unsigned MAX_SLOTS  = DEF_MAX_SLOTS,
  parameter int unsigned OWNER_BITS = DEF_OWNER_BITS,
  localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_pool_i,
  input  logic [IDX_W-1:0]      rd_idx_i,
  output logic                  rd_valid_o,
  output logic [OWNER_BITS-1:0] rd_owner_o,
  output logic [EPOCH_W-1:0]    rd_epoch_o,
  input  tsla_wr_ctl_t          wr_ctl_i,
  input  logic [IDX_W-1:0]      wr_idx_i,
  input  logic [OWNER_BITS-1:0] wr_owner_i,
  input  logic [EPOCH_W-1:0]    wr_epoch_i
);

  localparam int unsigned MEM_DEPTH = 2 * (1 << IDX_W);
  localparam int unsigned ENTRY_W   = OWNER_BITS + EPOCH_W;

  logic [ENTRY_W-1:0]            mem_q [MEM_DEPTH];
  logic [1:0][MAX_SLOTS-1:0]     valid_q;
  logic [ENTRY_W-1:0]            rd_data_q;
  logic                          rd_valid_q;

  // tag memory, no reset: entries count only where the valid bit is set
  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.en && wr_ctl_i.set_valid) begin
      mem_q[{wr_ctl_i.pool, wr_idx_i}] <= {wr_owner_i, wr_epoch_i};
    end
    rd_data_q <= mem_q[{rd_pool_i, rd_idx_i}];
  end

  // valid bits, all slots free after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_ctl_i.en) begin
        valid_q[wr_ctl_i.pool][wr_idx_i] <= wr_ctl_i.set_valid;
      end
      rd_valid_q <= valid_q[rd_pool_i][rd_idx_i];
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_owner_o = rd_data_q[ENTRY_W-1:EPOCH_W];
  assign rd_epoch_o = rd_data_q[EPOCH_W-1:0];

endmodule

// ----- sv/tsla_sequencer.sv -----
// request sequencer: scans one pool slot by slot through a shared tag
// comparator, then commits the store update and registers the result
// depends on tsla_pkg
module tsla_sequencer import tsla_pkg::*; #(
  parameter int unsigned MAX_SLOTS  = DEF_MAX_SLOTS,
  parameter int unsigned OWNER_BITS = DEF_OWNER_BITS,
  localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  tsla_req_t             req_i,
  input  logic [CFG_W-1:0]      active_slots_i,
  input  logic [CFG_W-1:0]      transfer_slots_i,
  output logic                  rd_pool_o,
  output logic [IDX_W-1:0]      rd_idx_o,
  input  logic                  rd_valid_i,
  input  logic [OWNER_BITS-1:0] rd_owner_i,
  input  logic [EPOCH_W-1:0]    rd_epoch_i,
  output tsla_wr_ctl_t          wr_ctl_o,
  output logic [IDX_W-1:0]      wr_idx_o,
  output logic [OWNER_BITS-1:0] wr_owner_o,
  output logic [EPOCH_W-1:0]    wr_epoch_o,
  output tsla_rsp_t             rsp_o,
  output logic                  rsp_valid_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CAP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SLOTS - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]       state_q, state_d;
  tsla_req_t        req_q;
  logic [CAP_W-1:0] cap_q;
  logic [IDX_W-1:0] idx_q, cmp_idx_q;
  logic             cmp_vld_q;
  logic [CNT_W-1:0] used_q;
  logic             found_q, free_found_q, rel_hit_q;
  logic [IDX_W-1:0] found_idx_q, free_idx_q;
  tsla_rsp_t        rsp_q;
  logic             rsp_valid_q;

  logic             accept;
  logic [CAP_W-1:0] cfg_cap, cap_sel;
  logic             tag_match;
  logic             in_range;
  logic [STATUS_W-1:0] fin_status;
  logic [IDX_W-1:0] fin_idx;
  logic [CNT_W-1:0] fin_used;
  logic [CAP_W-1:0] fin_used_ext;
  logic [CAP_W-1:0] fin_free;
  tsla_wr_ctl_t     fin_wr;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // capacity of the requested pool, clamped to the slot count
  assign cfg_cap = req_i.pool_select ? CAP_W'(transfer_slots_i) : CAP_W'(active_slots_i);
  assign cap_sel = (cfg_cap > CAP_W'(MAX_SLOTS)) ? CAP_W'(MAX_SLOTS) : cfg_cap;

  // shared tag comparator on the registered read data
  assign tag_match = rd_valid_i && (rd_owner_i == OWNER_BITS'(req_q.owner_id)) &&
                     (rd_epoch_i == req_q.owner_epoch);

  assign in_range = CAP_W'(req_q.slot_number) < cap_q;

  assign rd_pool_o = req_q.pool_select;
  assign rd_idx_o  = idx_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = S_SCAN;
      S_SCAN:   if (idx_q == LAST_IDX) state_d = S_DRAIN;
      S_DRAIN:  state_d = S_FINISH;
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // decision once the scan is complete
  always_comb begin
    fin_status = STATUS_OK;
    fin_idx    = '0;
    fin_used   = used_q;
    fin_wr     = '{en: 1'b0, set_valid: 1'b0, pool: req_q.pool_select};
    case (req_q.mode)
      MODE_ACQUIRE: begin
        if (found_q) begin
          fin_status = STATUS_DUP;
        end else if (!free_found_q) begin
          fin_status = STATUS_FULL;
        end else begin
          fin_idx          = free_idx_q;
          fin_used         = used_q + CNT_W'(1);
          fin_wr.en        = 1'b1;
          fin_wr.set_valid = 1'b1;
        end
      end
      MODE_RELEASE: begin
        if (!in_range) begin
          fin_status = STATUS_RANGE;
        end else if (!rel_hit_q) begin
          fin_status = STATUS_NOMATCH;
        end else begin
          fin_idx   = IDX_W'(req_q.slot_number);
          fin_used  = used_q - CNT_W'(1);
          fin_wr.en = 1'b1;
        end
      end
      default: begin
        if (found_q) begin
          fin_idx = found_idx_q;
        end else begin
          fin_status = STATUS_NOMATCH;
        end
      end
    endcase
    fin_used_ext = CAP_W'(fin_used);
    fin_free     = (fin_used_ext < cap_q) ? (cap_q - fin_used_ext) : '0;
  end

  // store write happens in the finish cycle
  always_comb begin
    wr_ctl_o = fin_wr;
    wr_ctl_o.en = fin_wr.en && (state_q == S_FINISH);
  end
  assign wr_idx_o   = fin_idx;
  assign wr_owner_o = OWNER_BITS'(req_q.owner_id);
  assign wr_epoch_o = req_q.owner_epoch;

  // request latch, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
      cap_q <= cap_sel;
    end
  end

  // sequencer and scan accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      cmp_idx_q    <= '0;
      cmp_vld_q    <= 1'b0;
      used_q       <= '0;
      found_q      <= 1'b0;
      found_idx_q  <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      rel_hit_q    <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= (state_q == S_FINISH);
      cmp_vld_q   <= (state_q == S_SCAN);
      cmp_idx_q   <= idx_q;
      if (accept) begin
        idx_q        <= '0;
        used_q       <= '0;
        found_q      <= 1'b0;
        found_idx_q  <= '0;
        free_found_q <= 1'b0;
        free_idx_q   <= '0;
        rel_hit_q    <= 1'b0;
      end else begin
        if (state_q == S_SCAN) begin
          idx_q <= idx_q + IDX_W'(1);
        end
        // one slot evaluated per cycle
        if (cmp_vld_q) begin
          if (rd_valid_i) begin
            used_q <= used_q + CNT_W'(1);
          end
          if (tag_match && !found_q) begin
            found_q     <= 1'b1;
            found_idx_q <= cmp_idx_q;
          end
          if (!rd_valid_i && !free_found_q && (CAP_W'(cmp_idx_q) < cap_q)) begin
            free_found_q <= 1'b1;
            free_idx_q   <= cmp_idx_q;
          end
          if (CAP_W'(cmp_idx_q) == CAP_W'(req_q.slot_number)) begin
            rel_hit_q <= tag_match;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == S_FINISH) begin
      rsp_q.status       <= fin_status;
      rsp_q.granted_slot <= (fin_status == STATUS_OK) ? GRANT_W'(fin_idx) : '0;
      rsp_q.used_count   <= COUNT_W'(fin_used);
      rsp_q.free_count   <= COUNT_W'(fin_free);
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

// ----- dv/tagged_slot_lease_allocator_test.sv -----
// testbench for the tagged slot lease allocator: directed and random requests,
// checked against a scoreboard that tracks both slot pools and the capacities
// depends on tsla_pkg and tagged_slot_lease_allocator
`timescale 1ns / 1ps

module tagged_slot_lease_allocator_test;
  import tsla_pkg::*;

  localparam int unsigned CLK_PERIOD      = 20;
  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned LIMIT_CYCLES    = 400000;
  localparam int unsigned TAGS            = 24;
  localparam int unsigned ITEMS_PER_PHASE = 98;
  localparam int unsigned SETTLE_CYCLES   = DEF_MAX_SLOTS + 4;
  localparam int unsigned PHASES          = 11;
  localparam int unsigned FIXED_PHASES    = 9;

  // the unused mode code, which the block treats as a lookup
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam logic [EPOCH_W-1:0] EPOCH_ZERO = {EPOCH_W{1'b0}};
  localparam logic [EPOCH_W-1:0] EPOCH_ONES = {EPOCH_W{1'b1}};

  // tracks slot ownership per pool and queues the expected results
  class slot_lease_scoreboard;
    bit                 held       [2][DEF_MAX_SLOTS];
    logic [ID_W-1:0]    held_id    [2][DEF_MAX_SLOTS];
    logic [EPOCH_W-1:0] held_epoch [2][DEF_MAX_SLOTS];
    logic [CFG_W-1:0]   cap_reg    [2];
    tsla_rsp_t          expected_q [$];
    int unsigned        errors;
    int unsigned        mode_tally [4];
    int unsigned        status_tally [8];

    function new();
      foreach (held[p, s]) begin
        held[p][s]       = 1'b0;
        held_id[p][s]    = '0;
        held_epoch[p][s] = EPOCH_ZERO;
      end
      cap_reg[0] = CFG_SLOTS_RESET;
      cap_reg[1] = CFG_SLOTS_RESET;
      errors     = 0;
      foreach (mode_tally[i]) mode_tally[i] = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_ACTIVE_SLOTS) begin
        cap_reg[0] = val;
      end else begin
        cap_reg[1] = val;
      end
    endfunction

    // register values above the slot count act as the slot count
    function int unsigned capacity(bit pool);
      return (cap_reg[pool] > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : int'(cap_reg[pool]);
    endfunction

    // slot holding the tag, or the slot count when no slot does
    function int unsigned find_tag(bit pool, logic [ID_W-1:0] id, logic [EPOCH_W-1:0] ep);
      for (int unsigned s = 0; s < DEF_MAX_SLOTS; s++) begin
        if (held[pool][s] && held_id[pool][s] == id && held_epoch[pool][s] == ep) return s;
      end
      return DEF_MAX_SLOTS;
    endfunction

    function void note_request(tsla_req_t r);
      tsla_rsp_t   want;
      bit          pool;
      int unsigned cap;
      int unsigned pick;
      int unsigned hit;
      int unsigned used;
      pool        = r.pool_select;
      cap         = capacity(pool);
      want        = '0;
      want.status = STATUS_OK;
      hit         = find_tag(pool, r.owner_id, r.owner_epoch);
      case (r.mode)
        MODE_ACQUIRE: begin
          if (hit < DEF_MAX_SLOTS) begin
            want.status = STATUS_DUP;
          end else begin
            // lowest free slot below the capacity
            pick = cap;
            for (int unsigned s = 0; s < cap && pick == cap; s++) begin
              if (!held[pool][s]) pick = s;
            end
            if (pick >= cap) begin
              want.status = STATUS_FULL;
            end else begin
              held[pool][pick]       = 1'b1;
              held_id[pool][pick]    = r.owner_id;
              held_epoch[pool][pick] = r.owner_epoch;
              want.granted_slot      = GRANT_W'(pick);
            end
          end
        end
        MODE_RELEASE: begin
          if (r.slot_number >= cap) begin
            want.status = STATUS_RANGE;
          end else if (!held[pool][r.slot_number] || held_id[pool][r.slot_number] != r.owner_id
                       || held_epoch[pool][r.slot_number] != r.owner_epoch) begin
            want.status = STATUS_NOMATCH;
          end else begin
            held[pool][r.slot_number]       = 1'b0;
            held_id[pool][r.slot_number]    = '0;
            held_epoch[pool][r.slot_number] = EPOCH_ZERO;
            want.granted_slot               = GRANT_W'(r.slot_number);
          end
        end
        // lookup, and the spare mode acting as one
        default: begin
          if (hit >= DEF_MAX_SLOTS) begin
            want.status = STATUS_NOMATCH;
          end else begin
            want.granted_slot = GRANT_W'(hit);
          end
        end
      endcase
      // counts of the selected pool after the step
      used = 0;
      for (int unsigned s = 0; s < DEF_MAX_SLOTS; s++) begin
        if (held[pool][s]) used++;
      end
      want.used_count = COUNT_W'(used);
      want.free_count = (used < cap) ? COUNT_W'(cap - used) : '0;
      mode_tally[r.mode]++;
      status_tally[want.status]++;
      expected_q = {expected_q, want};
    endfunction

    function bit field_wrong(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
        $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_result(tsla_rsp_t got);
      tsla_rsp_t want;
      bit        bad;
      if (expected_q.size() == 0) begin
        $display("[%0t] result with none pending: expected nothing, actual %p", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      bad  = field_wrong("status", want.status, got.status)
           | field_wrong("granted_slot", want.granted_slot, got.granted_slot)
           | field_wrong("used_count", want.used_count, got.used_count)
           | field_wrong("free_count", want.free_count, got.free_count);
      if (bad) errors++;
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  tsla_req_t            req;
  logic                 rsp_valid;
  tsla_rsp_t            rsp;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  slot_lease_scoreboard lease_sb;
  logic [ID_W-1:0]      tag_ids    [TAGS];
  logic [EPOCH_W-1:0]   tag_epochs [TAGS];
  int unsigned          cycle_count    = 0;
  int unsigned          settings_seen  = 1;
  int unsigned          active_caps   [FIXED_PHASES] = '{31, 16, 1, 4, 16, 7, 12, 2, 20};
  int unsigned          transfer_caps [FIXED_PHASES] = '{17, 16, 16, 0, 1, 9, 3, 16, 31};

  tagged_slot_lease_allocator dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .result_valid_o (rsp_valid),
    .rsp_o          (rsp),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // results cannot be held off, so every strobe is checked
  always @(posedge clk) begin
    if (rst_n && rsp_valid) lease_sb.check_result(rsp);
  end

  function automatic tsla_req_t make_req(logic [MODE_W-1:0] m, logic p, logic [ID_W-1:0] id,
                                         logic [EPOCH_W-1:0] ep, logic [SLOTNUM_W-1:0] s);
    tsla_req_t r;
    r.mode        = m;
    r.pool_select = p;
    r.owner_id    = id;
    r.owner_epoch = ep;
    r.slot_number = s;
    return r;
  endfunction

  // replace some tags; some share an id or an epoch with a neighbor
  function automatic void refresh_tags(int unsigned n);
    int unsigned k;
    int unsigned j;
    for (int unsigned i = 0; i < n; i++) begin
      k             = $urandom_range(0, TAGS - 1);
      j             = (k + 1) % TAGS;
      tag_ids[k]    = ID_W'($urandom);
      tag_epochs[k] = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0:       tag_ids[k] = tag_ids[j];
        1:       tag_epochs[k] = tag_epochs[j];
        2:       tag_epochs[k] = $urandom_range(0, 1) ? EPOCH_ONES : EPOCH_ZERO;
        default: ;
      endcase
    end
  endfunction

  // mostly well-formed requests on a small tag set, with near misses and noise
  function automatic tsla_req_t random_req(int unsigned acq_pct);
    tsla_req_t   r;
    int unsigned roll;
    int unsigned k;
    int unsigned s;
    int unsigned held_list [$];
    r.pool_select = 1'($urandom_range(0, 1));
    r.slot_number = SLOTNUM_W'($urandom_range(0, 31));
    k             = $urandom_range(0, TAGS - 1);
    r.owner_id    = tag_ids[k];
    r.owner_epoch = tag_epochs[k];
    roll          = $urandom_range(0, 99);
    if (roll < acq_pct) begin
      r.mode = MODE_ACQUIRE;
    end else if (roll < acq_pct + 30) begin
      r.mode = MODE_RELEASE;
      for (int unsigned i = 0; i < DEF_MAX_SLOTS; i++) begin
        if (lease_sb.held[r.pool_select][i]) held_list = {held_list, i};
      end
      if (held_list.size() != 0 && $urandom_range(0, 9) < 8) begin
        s             = held_list[$urandom_range(0, held_list.size() - 1)];
        r.slot_number = SLOTNUM_W'(s);
        r.owner_id    = lease_sb.held_id[r.pool_select][s];
        r.owner_epoch = lease_sb.held_epoch[r.pool_select][s];
        // near miss: one tag bit off
        if ($urandom_range(0, 5) == 0) begin
          if ($urandom_range(0, 1)) r.owner_id[$urandom_range(0, ID_W - 1)] ^= 1'b1;
          else r.owner_epoch[$urandom_range(0, EPOCH_W - 1)] ^= 1'b1;
        end
      end
    end else if (roll < 93) begin
      r.mode = ($urandom_range(0, 4) == 0) ? MODE_SPARE : MODE_LOOKUP;
    end else begin
      r.mode        = MODE_W'($urandom_range(0, 3));
      r.owner_id    = ID_W'($urandom);
      r.owner_epoch = {$urandom, $urandom};
    end
    return r;
  endfunction

  // hold start until the request is taken
  task automatic send(tsla_req_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy !== 1'b0);
    lease_sb.note_request(r);
  endtask

  // stop sending and wait for every pending result
  task automatic drain();
    start <= 1'b0;
    while (lease_sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacities(logic [CFG_W-1:0] active_cap, logic [CFG_W-1:0] transfer_cap);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_ACTIVE_SLOTS;
    cfg_wdata <= active_cap;
    @(posedge clk);
    lease_sb.write_reg(CFG_ACTIVE_SLOTS, active_cap);
    cfg_idx   <= CFG_TRANSFER_SLOTS;
    cfg_wdata <= transfer_cap;
    @(posedge clk);
    lease_sb.write_reg(CFG_TRANSFER_SLOTS, transfer_cap);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_seen++;
  endtask

  // bursts of random length separated by random gaps
  task automatic run_random(int unsigned n, int unsigned acq_pct);
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      send(random_req(acq_pct));
      burst_left--;
    end
  endtask

  // main sequence
  initial begin
    int unsigned a_cap;
    int unsigned t_cap;
    rst_n     = 1'b0;
    start     = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_ACTIVE_SLOTS;
    cfg_wdata = '0;
    lease_sb  = new();
    refresh_tags(TAGS * 3);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset capacities: empty pool, duplicates, bad releases, both pools
    send(make_req(MODE_LOOKUP, 1'b0, 12'h000, EPOCH_ZERO, 5'd0));
    send(make_req(MODE_RELEASE, 1'b0, 12'h000, EPOCH_ZERO, 5'd0));
    send(make_req(MODE_ACQUIRE, 1'b0, 12'h000, EPOCH_ZERO, 5'd31));
    send(make_req(MODE_ACQUIRE, 1'b0, 12'h000, EPOCH_ZERO, 5'd0));
    send(make_req(MODE_ACQUIRE, 1'b0, 12'hfff, EPOCH_ONES, 5'd0));
    send(make_req(MODE_SPARE, 1'b0, 12'hfff, EPOCH_ONES, 5'd0));
    send(make_req(MODE_RELEASE, 1'b0, 12'hfff, EPOCH_ONES, 5'd31));
    send(make_req(MODE_RELEASE, 1'b0, 12'hfff, EPOCH_ONES ^ 64'd1, 5'd1));
    send(make_req(MODE_RELEASE, 1'b0, 12'hfff, EPOCH_ONES, 5'd1));
    send(make_req(MODE_ACQUIRE, 1'b0, 12'h5a5, 64'h8000_0000_0000_0001, 5'd0));
    send(make_req(MODE_ACQUIRE, 1'b1, 12'h800, 64'h7fff_ffff_ffff_fffe, 5'd16));
    send(make_req(MODE_LOOKUP, 1'b1, 12'h800, 64'h7fff_ffff_ffff_fffe, 5'd0));
    send(make_req(MODE_RELEASE, 1'b1, 12'h800, 64'h7fff_ffff_ffff_fffe, 5'd15));

    // directed, capacities lowered below held slots, transfer pool at zero
    drain();
    set_capacities(5'd1, 5'd0);
    send(make_req(MODE_ACQUIRE, 1'b0, 12'h123, 64'd1, 5'd0));
    send(make_req(MODE_ACQUIRE, 1'b0, 12'h5a5, 64'h8000_0000_0000_0001, 5'd0));
    send(make_req(MODE_LOOKUP, 1'b0, 12'h5a5, 64'h8000_0000_0000_0001, 5'd0));
    send(make_req(MODE_RELEASE, 1'b0, 12'h5a5, 64'h8000_0000_0000_0001, 5'd1));
    send(make_req(MODE_RELEASE, 1'b0, 12'h000, EPOCH_ZERO, 5'd0));
    send(make_req(MODE_ACQUIRE, 1'b1, 12'h001, 64'd2, 5'd0));
    send(make_req(MODE_RELEASE, 1'b1, 12'h800, 64'h7fff_ffff_ffff_fffe, 5'd0));
    send(make_req(MODE_LOOKUP, 1'b1, 12'h800, 64'h7fff_ffff_ffff_fffe, 5'd0));

    // random phases, each under its own capacity setting
    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p < FIXED_PHASES) begin
        a_cap = active_caps[p];
        t_cap = transfer_caps[p];
      end else begin
        a_cap = $urandom_range(1, 31);
        t_cap = $urandom_range(0, 31);
      end
      drain();
      set_capacities(CFG_W'(a_cap), CFG_W'(t_cap));
      refresh_tags(8);
      run_random(ITEMS_PER_PHASE, $urandom_range(25, 55));
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("ran %0d acquire, %0d release, %0d lookup and %0d spare-mode requests, %0d settings",
             lease_sb.mode_tally[MODE_ACQUIRE], lease_sb.mode_tally[MODE_RELEASE],
             lease_sb.mode_tally[MODE_LOOKUP], lease_sb.mode_tally[MODE_SPARE], settings_seen);
    $display("outcomes: %0d ok, %0d duplicate, %0d full, %0d no match, %0d out of range",
             lease_sb.status_tally[STATUS_OK], lease_sb.status_tally[STATUS_DUP],
             lease_sb.status_tally[STATUS_FULL], lease_sb.status_tally[STATUS_NOMATCH],
             lease_sb.status_tally[STATUS_RANGE]);
    if (lease_sb.errors == 0 && lease_sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
